FILE: src/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape package
// Result kinds, error codes and character constants shared by the design.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_NO_QUOTE  = 3'd1,
    ERR_CONTROL   = 3'd2,
    ERR_ESCAPE    = 3'd3,
    ERR_HEX       = 3'd4,
    ERR_SURROGATE = 3'd5
  } err_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam logic [7:0] BYTE_BS   = 8'h08;
  localparam logic [7:0] BYTE_FF   = 8'h0c;
  localparam logic [7:0] BYTE_LF   = 8'h0a;
  localparam logic [7:0] BYTE_CR   = 8'h0d;
  localparam logic [7:0] BYTE_TAB  = 8'h09;

  localparam logic [15:0] HIGH_SURR_LO = 16'hd800;
  localparam logic [15:0] HIGH_SURR_HI = 16'hdbff;
  localparam logic [15:0] LOW_SURR_LO  = 16'hdc00;
  localparam logic [15:0] LOW_SURR_HI  = 16'hdfff;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

endpackage

FILE: src/jsu_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape channels
// Valid/ready channels for raw input bytes and for decoded results.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink (input valid, input in_byte, input stream_end, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last, input ready);
  modport sink (input valid, input out_byte, input kind, input error_code,
                input last, output ready);
endinterface

FILE: src/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8
// Takes raw text one byte per item, decodes one JSON string at a time and
// emits its UTF-8 bytes, an end marker or an error.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one raw byte per item, or an end-of-input flag. out_i
//   returns results: data bytes, a string-end marker or an error, with last
//   set on the final result caused by each input item.
//   Each item is decoded in the cycle it is accepted and its results are
//   held in a four-entry result register, so the first result is valid in the
//   cycle after acceptance.
//   An item with zero or one result can be accepted every cycle while results
//   are taken. After an item with two to four results (a multi-byte UTF-8
//   sequence), the next item is taken in the cycle its last result leaves.
//   When the receiver stalls, the result register holds and in_i.ready drops
//   once a result is pending that is not being taken.
//   Reset returns the parser to idle, waiting for an opening quote, and
//   empties the result register.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 (
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_STR   = 4'd1,
    PH_ESC   = 4'd2,
    PH_HEX1  = 4'd3,
    PH_LOWBS = 4'd4,
    PH_LOWU  = 4'd5,
    PH_HEX2  = 4'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  dcnt_q, dcnt_d;
  logic [9:0]  high_q, high_d;

  logic [7:0]  res_byte_q [4];
  jsu_pkg::kind_e res_kind_q;
  jsu_pkg::err_e  res_err_q;
  logic [2:0]  res_cnt_q;
  logic [1:0]  res_idx_q;

  logic [7:0]  new_byte [4];
  jsu_pkg::kind_e new_kind;
  jsu_pkg::err_e  new_err;
  logic [2:0]  new_cnt;

  logic        accept;
  logic        out_last;
  logic        pop;
  logic [7:0]  c;
  logic [3:0]  digit;
  logic        digit_ok;
  logic [15:0] acc_next;
  logic [20:0] supp_code;

  assign c        = in_i.in_byte;
  assign accept   = in_i.valid && in_i.ready;
  assign out_last = ({1'b0, res_idx_q} == (res_cnt_q - 3'd1));
  assign pop      = out_o.valid && out_o.ready;

  assign in_i.ready       = (res_cnt_q == 3'd0) || (pop && out_last);
  assign out_o.valid      = (res_cnt_q != 3'd0);
  assign out_o.out_byte   = res_byte_q[res_idx_q];
  assign out_o.kind       = res_kind_q;
  assign out_o.error_code = res_err_q;
  assign out_o.last       = out_last;

  always_comb begin
    digit_ok = 1'b1;
    digit    = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      digit = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      digit = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      digit = 4'(c - 8'h57);
    end else begin
      digit_ok = 1'b0;
    end
  end

  assign acc_next  = {hex_q[11:0], digit};
  assign supp_code = jsu_pkg::SUPP_BASE + {1'b0, high_q, acc_next[9:0]};

  always_comb begin
    phase_d  = phase_q;
    hex_d    = hex_q;
    dcnt_d   = dcnt_q;
    high_d   = high_q;
    new_cnt  = 3'd0;
    new_kind = jsu_pkg::KIND_DATA;
    new_err  = jsu_pkg::ERR_NONE;
    for (int i = 0; i < 4; i++) begin
      new_byte[i] = 8'h00;
    end

    if (phase_q == PH_IDLE) begin
      if (!in_i.stream_end) begin
        if (c == jsu_pkg::CH_QUOTE) begin
          phase_d = PH_STR;
        end else if (!((c >= 8'h09 && c <= 8'h0d) || c == jsu_pkg::CH_SPACE)) begin
          new_cnt  = 3'd1;
          new_kind = jsu_pkg::KIND_ERR;
          new_err  = jsu_pkg::ERR_NO_QUOTE;
        end
      end
    end else if (in_i.stream_end) begin
      phase_d  = PH_IDLE;
      new_cnt  = 3'd1;
      new_kind = jsu_pkg::KIND_ERR;
      new_err  = jsu_pkg::ERR_SURROGATE;
    end else begin
      case (phase_q)
        PH_STR: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            phase_d  = PH_IDLE;
            new_cnt  = 3'd1;
            new_kind = jsu_pkg::KIND_END;
          end else if (c <= 8'h1f || c == jsu_pkg::CH_DEL) begin
            phase_d  = PH_IDLE;
            new_cnt  = 3'd1;
            new_kind = jsu_pkg::KIND_ERR;
            new_err  = jsu_pkg::ERR_CONTROL;
          end else if (c == jsu_pkg::CH_BSLASH) begin
            phase_d = PH_ESC;
          end else begin
            new_cnt     = 3'd1;
            new_byte[0] = c;
          end
        end
        PH_ESC: begin
          phase_d = PH_STR;
          new_cnt = 3'd1;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: new_byte[0] = c;
            jsu_pkg::CH_B: new_byte[0] = jsu_pkg::BYTE_BS;
            jsu_pkg::CH_F: new_byte[0] = jsu_pkg::BYTE_FF;
            jsu_pkg::CH_N: new_byte[0] = jsu_pkg::BYTE_LF;
            jsu_pkg::CH_R: new_byte[0] = jsu_pkg::BYTE_CR;
            jsu_pkg::CH_T: new_byte[0] = jsu_pkg::BYTE_TAB;
            jsu_pkg::CH_U: begin
              phase_d = PH_HEX1;
              hex_d   = 16'h0000;
              dcnt_d  = 2'd0;
              new_cnt = 3'd0;
            end
            default: begin
              phase_d  = PH_IDLE;
              new_kind = jsu_pkg::KIND_ERR;
              new_err  = jsu_pkg::ERR_ESCAPE;
            end
          endcase
        end
        PH_LOWBS: begin
          if (c == jsu_pkg::CH_BSLASH) begin
            phase_d = PH_LOWU;
          end else begin
            phase_d  = PH_IDLE;
            new_cnt  = 3'd1;
            new_kind = jsu_pkg::KIND_ERR;
            new_err  = jsu_pkg::ERR_SURROGATE;
          end
        end
        PH_LOWU: begin
          if (c == jsu_pkg::CH_U) begin
            phase_d = PH_HEX2;
            hex_d   = 16'h0000;
            dcnt_d  = 2'd0;
          end else begin
            phase_d  = PH_IDLE;
            new_cnt  = 3'd1;
            new_kind = jsu_pkg::KIND_ERR;
            new_err  = jsu_pkg::ERR_SURROGATE;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (!digit_ok) begin
            phase_d  = PH_IDLE;
            new_cnt  = 3'd1;
            new_kind = jsu_pkg::KIND_ERR;
            new_err  = jsu_pkg::ERR_HEX;
          end else begin
            hex_d = acc_next;
            if (dcnt_q != 2'd3) begin
              dcnt_d = dcnt_q + 2'd1;
            end else begin
              dcnt_d = 2'd0;
              if (phase_q == PH_HEX1) begin
                if (acc_next >= jsu_pkg::HIGH_SURR_LO && acc_next <= jsu_pkg::HIGH_SURR_HI) begin
                  high_d  = acc_next[9:0];
                  phase_d = PH_LOWBS;
                end else if (acc_next >= jsu_pkg::LOW_SURR_LO &&
                             acc_next <= jsu_pkg::LOW_SURR_HI) begin
                  phase_d  = PH_IDLE;
                  new_cnt  = 3'd1;
                  new_kind = jsu_pkg::KIND_ERR;
                  new_err  = jsu_pkg::ERR_SURROGATE;
                end else begin
                  phase_d = PH_STR;
                  if (acc_next < 16'h0080) begin
                    new_cnt     = 3'd1;
                    new_byte[0] = acc_next[7:0];
                  end else if (acc_next < 16'h0800) begin
                    new_cnt     = 3'd2;
                    new_byte[0] = {3'b110, acc_next[10:6]};
                    new_byte[1] = {2'b10, acc_next[5:0]};
                  end else begin
                    new_cnt     = 3'd3;
                    new_byte[0] = {4'b1110, acc_next[15:12]};
                    new_byte[1] = {2'b10, acc_next[11:6]};
                    new_byte[2] = {2'b10, acc_next[5:0]};
                  end
                end
              end else if (acc_next < jsu_pkg::LOW_SURR_LO || acc_next > jsu_pkg::LOW_SURR_HI) begin
                phase_d  = PH_IDLE;
                new_cnt  = 3'd1;
                new_kind = jsu_pkg::KIND_ERR;
                new_err  = jsu_pkg::ERR_SURROGATE;
              end else begin
                phase_d     = PH_STR;
                new_cnt     = 3'd4;
                new_byte[0] = {5'b11110, supp_code[20:18]};
                new_byte[1] = {2'b10, supp_code[17:12]};
                new_byte[2] = {2'b10, supp_code[11:6]};
                new_byte[3] = {2'b10, supp_code[5:0]};
              end
            end
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      hex_q     <= 16'h0000;
      dcnt_q    <= 2'd0;
      high_q    <= 10'd0;
      res_cnt_q <= 3'd0;
      res_idx_q <= 2'd0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
        hex_q   <= hex_d;
        dcnt_q  <= dcnt_d;
        high_q  <= high_d;
      end
      if (accept && new_cnt != 3'd0) begin
        res_cnt_q <= new_cnt;
        res_idx_q <= 2'd0;
      end else if (pop) begin
        if (out_last) begin
          res_cnt_q <= 3'd0;
          res_idx_q <= 2'd0;
        end else begin
          res_idx_q <= res_idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && new_cnt != 3'd0) begin
      for (int i = 0; i < 4; i++) begin
        res_byte_q[i] <= new_byte[i];
      end
      res_kind_q <= new_kind;
      res_err_q  <= new_err;
    end
  end

`ifndef SYNTHESIS
  a_no_accept_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_cnt_q != 3'd0 && !(out_o.ready && out_last)) |-> !in_i.ready)
    else $error("Input item accepted while results are still pending.");

  a_error_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && new_kind == jsu_pkg::KIND_ERR && new_cnt != 3'd0) |=> (phase_q == PH_IDLE))
    else $error("Parser did not return to idle after an error.");

  a_marker_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != jsu_pkg::KIND_DATA) |->
      (out_o.last && out_o.out_byte == 8'h00 && res_cnt_q == 3'd1))
    else $error("End or error result is not a lone zero-byte item.");

  a_data_no_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind == jsu_pkg::KIND_DATA) |-> (out_o.error_code == jsu_pkg::ERR_NONE))
    else $error("Data item carries an error code.");
`endif

endmodule

FILE: tb/json_string_unescape_utf8_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// JSON string unescape to UTF-8 testbench
// Feeds raw text bytes through a short table of directed items and then
// random JSON strings with clean and broken escapes, while both channels idle
// at random. Results are matched to a local behavioral decoder or a table row.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_test;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_ITEMS    = 310;
  localparam int TAIL_CYCLES    = 20;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TEXT, ST_ESCAPE, ST_HEX_HIGH, ST_LOW_BSLASH, ST_LOW_U, ST_HEX_LOW
  } parse_state_e;

  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_ONE} check_e;

  typedef struct {
    logic [7:0]     out_byte;
    jsu_pkg::kind_e kind;
    jsu_pkg::err_e  err;
    logic           last;
  } result_t;

  typedef struct {
    logic [7:0]     ch;
    logic           eos;
    check_e         how;
    logic [7:0]     ob;
    jsu_pkg::kind_e kind;
    jsu_pkg::err_e  err;
  } stim_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch.sink),
    .out_o  (out_ch.source)
  );

  always #10 clk_i = ~clk_i;

  parse_state_e st = ST_IDLE;
  logic [15:0]  hex_acc = '0;
  logic [1:0]   hex_count = '0;
  logic [9:0]   high_bits = '0;

  result_t   step_results[$];
  result_t   decoded_q[$];
  stim_row_t directed_rows[$];
  result_t   want;
  int        fail_count = 0;
  int        sent_items = 0;
  int        quiet_cycles = 0;
  bit        calm = 1'b0;

  function automatic bit is_ws(input logic [7:0] c);
    return (c >= 8'h09 && c <= 8'h0d) || c == jsu_pkg::CH_SPACE;
  endfunction

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    return -1;
  endfunction

  function automatic void put_result(input logic [7:0] b, input jsu_pkg::kind_e k,
                                     input jsu_pkg::err_e e);
    result_t r;
    r.out_byte = b;
    r.kind     = k;
    r.err      = e;
    r.last     = 1'b0;
    step_results.insert(step_results.size(), r);
  endfunction

  function automatic void give_error(input jsu_pkg::err_e e);
    st = ST_IDLE;
    put_result(8'h00, jsu_pkg::KIND_ERR, e);
  endfunction

  function automatic void emit_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      put_result(cp[7:0], jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h800) begin
      put_result({3'b110, cp[10:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else if (cp < 21'h10000) begin
      put_result({4'b1110, cp[15:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end else begin
      put_result({5'b11110, cp[20:18]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[17:12]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[11:6]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
      put_result({2'b10, cp[5:0]}, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
    end
    st = ST_TEXT;
  endfunction

  // Advances the decoder by one raw byte and leaves its results in step_results.
  function automatic void unescape_byte(input logic [7:0] c, input logic eos);
    int d;
    step_results.delete();
    if (st == ST_IDLE) begin
      if (!eos && !is_ws(c)) begin
        if (c == jsu_pkg::CH_QUOTE) st = ST_TEXT;
        else give_error(jsu_pkg::ERR_NO_QUOTE);
      end
    end else if (eos) begin
      give_error(jsu_pkg::ERR_SURROGATE);
    end else begin
      case (st)
        ST_TEXT: begin
          if (c == jsu_pkg::CH_QUOTE) begin
            st = ST_IDLE;
            put_result(8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);
          end else if (c <= 8'h1f || c == jsu_pkg::CH_DEL) begin
            give_error(jsu_pkg::ERR_CONTROL);
          end else if (c == jsu_pkg::CH_BSLASH) begin
            st = ST_ESCAPE;
          end else begin
            put_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
          end
        end
        ST_ESCAPE: begin
          st = ST_TEXT;
          case (c)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH:
              put_result(c, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_B: put_result(jsu_pkg::BYTE_BS, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_F: put_result(jsu_pkg::BYTE_FF, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_N: put_result(jsu_pkg::BYTE_LF, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_R: put_result(jsu_pkg::BYTE_CR, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_T: put_result(jsu_pkg::BYTE_TAB, jsu_pkg::KIND_DATA, jsu_pkg::ERR_NONE);
            jsu_pkg::CH_U: begin
              st = ST_HEX_HIGH;
              hex_acc = '0;
              hex_count = '0;
            end
            default: give_error(jsu_pkg::ERR_ESCAPE);
          endcase
        end
        ST_LOW_BSLASH: begin
          if (c != jsu_pkg::CH_BSLASH) give_error(jsu_pkg::ERR_SURROGATE);
          else st = ST_LOW_U;
        end
        ST_LOW_U: begin
          if (c != jsu_pkg::CH_U) begin
            give_error(jsu_pkg::ERR_SURROGATE);
          end else begin
            st = ST_HEX_LOW;
            hex_acc = '0;
            hex_count = '0;
          end
        end
        default: begin
          d = hex_digit(c);
          if (d < 0) begin
            give_error(jsu_pkg::ERR_HEX);
          end else begin
            hex_acc = {hex_acc[11:0], d[3:0]};
            if (hex_count != 2'd3) begin
              hex_count = hex_count + 2'd1;
            end else begin
              hex_count = '0;
              if (st == ST_HEX_HIGH) begin
                if (hex_acc >= jsu_pkg::HIGH_SURR_LO && hex_acc <= jsu_pkg::HIGH_SURR_HI) begin
                  high_bits = hex_acc[9:0];
                  st = ST_LOW_BSLASH;
                end else if (hex_acc >= jsu_pkg::LOW_SURR_LO &&
                             hex_acc <= jsu_pkg::LOW_SURR_HI) begin
                  give_error(jsu_pkg::ERR_SURROGATE);
                end else begin
                  emit_utf8({5'd0, hex_acc});
                end
              end else if (hex_acc < jsu_pkg::LOW_SURR_LO || hex_acc > jsu_pkg::LOW_SURR_HI) begin
                give_error(jsu_pkg::ERR_SURROGATE);
              end else begin
                emit_utf8(jsu_pkg::SUPP_BASE + {1'b0, high_bits, hex_acc[9:0]});
              end
            end
          end
        end
      endcase
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 8) return int'($urandom_range(1, 3));
    return int'($urandom_range(8, 30));
  endfunction

  task automatic drive_item(input logic [7:0] c, input logic eos);
    int gap;
    gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= c;
    in_ch.stream_end <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic feed(input logic [7:0] c, input logic eos, input check_e how = CHK_MODEL,
                      input logic [7:0] ob = 8'h00,
                      input jsu_pkg::kind_e kind = jsu_pkg::KIND_DATA,
                      input jsu_pkg::err_e err = jsu_pkg::ERR_NONE);
    result_t r;
    sent_items++;
    unescape_byte(c, eos);
    case (how)
      CHK_MODEL: foreach (step_results[i]) decoded_q.insert(decoded_q.size(), step_results[i]);
      CHK_ONE: begin
        r.out_byte = ob;
        r.kind     = kind;
        r.err      = err;
        r.last     = 1'b1;
        decoded_q.insert(decoded_q.size(), r);
      end
      default: ;
    endcase
    drive_item(c, eos);
  endtask

  function automatic void add_row(input logic [7:0] ch, input logic eos, input check_e how,
                                  input logic [7:0] ob = 8'h00,
                                  input jsu_pkg::kind_e kind = jsu_pkg::KIND_DATA,
                                  input jsu_pkg::err_e err = jsu_pkg::ERR_NONE);
    stim_row_t row;
    row.ch   = ch;
    row.eos  = eos;
    row.how  = how;
    row.ob   = ob;
    row.kind = kind;
    row.err  = err;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  function automatic logic [7:0] nibble_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 1)) return 8'($urandom_range(8'h80, 8'hff));
    do b = 8'($urandom_range(8'h20, 8'h7e));
    while (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH);
    return b;
  endfunction

  function automatic logic [7:0] escape_byte();
    case ($urandom_range(0, 7))
      0: return jsu_pkg::CH_QUOTE;
      1: return jsu_pkg::CH_BSLASH;
      2: return jsu_pkg::CH_SLASH;
      3: return jsu_pkg::CH_B;
      4: return jsu_pkg::CH_F;
      5: return jsu_pkg::CH_N;
      6: return jsu_pkg::CH_R;
      default: return jsu_pkg::CH_T;
    endcase
  endfunction

  function automatic logic [15:0] bmp_code();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 7))
          0: return 16'h0000;
          1: return 16'h007f;
          2: return 16'h0080;
          3: return 16'h07ff;
          4: return 16'h0800;
          5: return 16'hd7ff;
          6: return 16'he000;
          default: return 16'hffff;
        endcase
      end
      1, 2: return 16'($urandom_range(16'h0000, 16'h007f));
      3, 4: return 16'($urandom_range(16'h0080, 16'h07ff));
      5, 6, 7: return 16'($urandom_range(16'h0800, 16'hd7ff));
      default: return 16'($urandom_range(16'he000, 16'hffff));
    endcase
  endfunction

  task automatic feed_unicode(input logic [15:0] code);
    feed(jsu_pkg::CH_BSLASH, 1'b0);
    feed(jsu_pkg::CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) feed(nibble_char(code[i*4 +: 4]), 1'b0);
  endtask

  // One JSON string, mostly well formed; some strings are cut short by a
  // broken escape, a bad surrogate pair, a control byte or end of input.
  task automatic random_string();
    int r;
    logic [15:0] lo;
    logic [7:0] b;
    repeat ($urandom_range(0, 2)) begin
      r = int'($urandom_range(0, 5));
      feed((r == 5) ? jsu_pkg::CH_SPACE : 8'h09 + r[7:0], 1'b0);
    end
    r = int'($urandom_range(0, 99));
    if (r < 6) feed(8'($urandom_range(0, 255)), 1'b0);
    else if (r < 9) feed(8'($urandom_range(0, 255)), 1'b1);
    feed(jsu_pkg::CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 10)) begin
      r = int'($urandom_range(0, 99));
      if (r < 45) begin
        feed(text_byte(), 1'b0);
      end else if (r < 63) begin
        feed(jsu_pkg::CH_BSLASH, 1'b0);
        feed(escape_byte(), 1'b0);
      end else if (r < 80) begin
        feed_unicode(bmp_code());
      end else if (r < 92) begin
        feed_unicode(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
        feed_unicode(16'($urandom_range(jsu_pkg::LOW_SURR_LO, jsu_pkg::LOW_SURR_HI)));
      end else begin
        case ($urandom_range(0, 7))
          0: begin
            feed(jsu_pkg::CH_BSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b inside {jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
                             jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
                             jsu_pkg::CH_T, jsu_pkg::CH_U});
            feed(b, 1'b0);
          end
          1: begin
            feed(jsu_pkg::CH_BSLASH, 1'b0);
            feed(jsu_pkg::CH_U, 1'b0);
            repeat ($urandom_range(0, 3)) feed(nibble_char(4'($urandom_range(0, 15))), 1'b0);
            do b = 8'($urandom_range(0, 255)); while (hex_digit(b) >= 0);
            feed(b, 1'b0);
          end
          2: feed_unicode(16'($urandom_range(jsu_pkg::LOW_SURR_LO, jsu_pkg::LOW_SURR_HI)));
          3: begin
            feed_unicode(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_BSLASH);
            feed(b, $urandom_range(0, 3) == 0);
          end
          4: begin
            feed_unicode(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
            feed(jsu_pkg::CH_BSLASH, 1'b0);
            do b = 8'($urandom_range(0, 255)); while (b == jsu_pkg::CH_U);
            feed(b, 1'b0);
          end
          5: begin
            feed_unicode(16'($urandom_range(jsu_pkg::HIGH_SURR_LO, jsu_pkg::HIGH_SURR_HI)));
            do lo = 16'($urandom_range(0, 16'hffff));
            while (lo >= jsu_pkg::LOW_SURR_LO && lo <= jsu_pkg::LOW_SURR_HI);
            feed_unicode(lo);
          end
          6: begin
            feed(jsu_pkg::CH_BSLASH, 1'b0);
            feed(jsu_pkg::CH_U, 1'b0);
            repeat ($urandom_range(0, 3)) feed(nibble_char(4'($urandom_range(0, 15))), 1'b0);
            feed(8'($urandom_range(0, 255)), 1'b1);
          end
          default: begin
            if ($urandom_range(0, 3) == 0) feed(jsu_pkg::CH_DEL, 1'b0);
            else feed(8'($urandom_range(0, 8'h1f)), 1'b0);
          end
        endcase
        return;
      end
    end
    r = int'($urandom_range(0, 99));
    if (r < 88) feed(jsu_pkg::CH_QUOTE, 1'b0);
    else if (r < 94) feed(8'($urandom_range(0, 255)), 1'b1);
    else feed(8'($urandom_range(0, 8'h1f)), 1'b0);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      int stall_left;
      @(posedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 20) begin
        stall_left = idle_len() - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (decoded_q.size() == 0) begin
        $error("result with nothing expected: out_byte %02h kind %0d error_code %0d",
               out_ch.out_byte, out_ch.kind, out_ch.error_code);
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        if (out_ch.out_byte !== want.out_byte) begin
          $error("out_byte: expected %02h, got %02h", want.out_byte, out_ch.out_byte);
          fail_count++;
        end
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          fail_count++;
        end
        if (out_ch.error_code !== want.err) begin
          $error("error_code: expected %0d, got %0d", want.err, out_ch.error_code);
          fail_count++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("Test completed with failures");
          $finish;
        end
      end
    end
  end

  initial begin
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= 8'h00;
    in_ch.stream_end <= 1'b0;

    add_row(jsu_pkg::CH_SPACE,  1'b0, CHK_NONE);
    add_row(8'h41,              1'b0, CHK_ONE, 8'h00, jsu_pkg::KIND_ERR, jsu_pkg::ERR_NO_QUOTE);
    add_row(8'h00,              1'b1, CHK_NONE);
    add_row(jsu_pkg::CH_QUOTE,  1'b0, CHK_NONE);
    add_row(8'h80,              1'b0, CHK_ONE, 8'h80);
    add_row(8'hff,              1'b0, CHK_ONE, 8'hff);
    add_row(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE);
    add_row(jsu_pkg::CH_T,      1'b0, CHK_ONE, jsu_pkg::BYTE_TAB);
    add_row(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE);
    add_row(jsu_pkg::CH_U,      1'b0, CHK_NONE);
    add_row(8'h44,              1'b0, CHK_MODEL);
    add_row(8'h62,              1'b0, CHK_MODEL);
    add_row(8'h46,              1'b0, CHK_MODEL);
    add_row(8'h66,              1'b0, CHK_MODEL);
    add_row(jsu_pkg::CH_BSLASH, 1'b0, CHK_MODEL);
    add_row(jsu_pkg::CH_U,      1'b0, CHK_MODEL);
    add_row(8'h44,              1'b0, CHK_MODEL);
    add_row(8'h46,              1'b0, CHK_MODEL);
    add_row(8'h66,              1'b0, CHK_MODEL);
    add_row(8'h46,              1'b0, CHK_MODEL);
    add_row(jsu_pkg::CH_DEL,    1'b0, CHK_ONE, 8'h00, jsu_pkg::KIND_ERR, jsu_pkg::ERR_CONTROL);
    add_row(jsu_pkg::CH_QUOTE,  1'b0, CHK_NONE);
    add_row(jsu_pkg::CH_BSLASH, 1'b0, CHK_NONE);
    add_row(8'h71,              1'b0, CHK_ONE, 8'h00, jsu_pkg::KIND_ERR, jsu_pkg::ERR_ESCAPE);
    add_row(jsu_pkg::CH_QUOTE,  1'b0, CHK_NONE);
    add_row(8'hff,              1'b1, CHK_ONE, 8'h00, jsu_pkg::KIND_ERR,
            jsu_pkg::ERR_SURROGATE);
    add_row(jsu_pkg::CH_QUOTE,  1'b0, CHK_NONE);
    add_row(jsu_pkg::CH_QUOTE,  1'b0, CHK_ONE, 8'h00, jsu_pkg::KIND_END, jsu_pkg::ERR_NONE);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      feed(directed_rows[i].ch, directed_rows[i].eos, directed_rows[i].how,
           directed_rows[i].ob, directed_rows[i].kind, directed_rows[i].err);
    end

    while (sent_items < TOTAL_ITEMS) begin
      if ($urandom_range(0, 11) == 0) calm = !calm;
      random_string();
    end
    in_ch.valid <= 1'b0;

    wait (decoded_q.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
